// ===== sv/ddf_pkg.sv =====
// Shared types and constants for the detection decision filter.
// Used by every module of the block; depends on nothing else.
package ddf_pkg;

	localparam int NUM_CLASSES_DEF = 10;
	localparam int COUNT_BITS_DEF  = 32;

	localparam int WIN_W    = 32;
	localparam int SCORE_W  = 16;
	localparam int PEAK_W   = 16;
	localparam int CLASS_W  = 4;
	localparam int MASK_W   = 10;
	localparam int PCT_W    = 7;
	localparam int CNT_OUT_W = 32;
	localparam int ADDR_W   = 2;
	localparam int CFG_W    = 16;

	localparam logic [ADDR_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [ADDR_W-1:0] REG_GATE      = 2'd1;
	localparam logic [ADDR_W-1:0] REG_MASK      = 2'd2;

	localparam logic [SCORE_W-1:0] THRESHOLD_RST = 16'h8000;
	localparam logic [PCT_W-1:0]   PCT_MAX       = 7'd100;
	localparam logic [6:0]         PCT_SCALE     = 7'd100;
	localparam logic [22:0]        PCT_ROUND     = 23'd32768;

	typedef enum logic [1:0] {
		ACT_TARGET     = 2'd0,
		ACT_UNKNOWN    = 2'd1,
		ACT_HELD       = 2'd2,
		ACT_SUPPRESSED = 2'd3
	} action_t;

	typedef struct packed {
		logic [CLASS_W-1:0] top;
		logic [SCORE_W-1:0] best;
	} pick_t;

	typedef struct packed {
		logic [SCORE_W-1:0] threshold;
		logic [SCORE_W-1:0] gate;
		logic [MASK_W-1:0]  mask;
	} cfg_t;

	typedef struct packed {
		logic [WIN_W-1:0]     window;
		action_t              action;
		logic [CLASS_W-1:0]   cls;
		logic [PCT_W-1:0]     pct;
		logic                 led;
		logic                 gated;
		logic [CNT_OUT_W-1:0] reported;
		logic [CNT_OUT_W-1:0] held;
		logic [CNT_OUT_W-1:0] suppressed;
		logic [CNT_OUT_W-1:0] gated_cnt;
	} result_t;

endpackage

// ===== sv/detection_decision_filter.sv =====
// Top level of the detection decision filter: input and result handshakes, registers.
// Depends on ddf_pkg, ddf_lane, ddf_merge and ddf_decide.
// Channel  | dir | payload (tdata, low bits first)
// s_axis   | in  | window_number, score_0..score_N-1, peak_amplitude
// m_axis   | out | window_out, action, class_out, percent, led_trigger, was_gated, 4 counts
// cfg      | in  | cfg_wr_en, cfg_addr, cfg_wdata (0 threshold, 1 gate, 2 target mask)
// One item per cycle while the output is not stalled; a result is offered once its
// item has passed the lane, merge and decision registers.
// Stage one is the class lanes, stage two the merge, stage three the decision and
// output register. A stall at the output fills the stages behind it before
// s_tready drops. Reset clears the valids, gate, mask and totals and sets threshold 0x8000.
module detection_decision_filter #(
	parameter int NUM_CLASSES = ddf_pkg::NUM_CLASSES_DEF,
	parameter int COUNT_BITS  = ddf_pkg::COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// window_number, score_0 .. score_(NUM_CLASSES-1), peak_amplitude
	input  logic [((ddf_pkg::WIN_W + NUM_CLASSES*ddf_pkg::SCORE_W + ddf_pkg::PEAK_W + 7)
		/ 8) * 8 - 1:0]                 s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// window_out, action, class_out, percent, led_trigger, was_gated,
	// reported_count, held_count, suppressed_count, gated_count, one pad bit
	output logic [175:0]                m_tdata,
	input  logic                        cfg_wr_en,
	input  logic [ddf_pkg::ADDR_W-1:0]  cfg_addr,
	input  logic [ddf_pkg::CFG_W-1:0]   cfg_wdata
);

	localparam int SCORES_W = NUM_CLASSES * ddf_pkg::SCORE_W;
	localparam int PEAK_LO  = ddf_pkg::WIN_W + SCORES_W;

	ddf_pkg::cfg_t                  cfg_q;
	logic                           vld_s1, vld_s2, vld_s3;
	logic                           rdy1, rdy2, rdy3;
	logic [ddf_pkg::WIN_W-1:0]      window_s1, window_s2;
	logic [ddf_pkg::PEAK_W-1:0]     peak_s1, peak_s2;
	logic [NUM_CLASSES-1:0]         win_s1;
	logic [SCORES_W-1:0]            score_s1;
	ddf_pkg::pick_t                 pick_s2;
	ddf_pkg::result_t               result_q;

	assign rdy3     = !vld_s3 || m_tready;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign s_tready = rdy1;
	assign m_tvalid = vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy1)
				vld_s1 <= s_tvalid;
			if (rdy2)
				vld_s2 <= vld_s1;
			if (rdy3)
				vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= ddf_pkg::THRESHOLD_RST;
			cfg_q.gate      <= '0;
			cfg_q.mask      <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				ddf_pkg::REG_THRESHOLD: cfg_q.threshold <= cfg_wdata;
				ddf_pkg::REG_GATE:      cfg_q.gate      <= cfg_wdata;
				ddf_pkg::REG_MASK:      cfg_q.mask      <= cfg_wdata[ddf_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			window_s1 <= s_tdata[ddf_pkg::WIN_W-1:0];
			peak_s1   <= s_tdata[PEAK_LO +: ddf_pkg::PEAK_W];
		end
		if (rdy2) begin
			window_s2 <= window_s1;
			peak_s2   <= peak_s1;
		end
	end

	for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_lane
		ddf_lane #(
			.NUM_CLASSES(NUM_CLASSES),
			.LANE       (g)
		) u_lane (
			.clk     (clk),
			.en      (rdy1),
			.scores  (s_tdata[ddf_pkg::WIN_W +: SCORES_W]),
			.score_s1(score_s1[g*ddf_pkg::SCORE_W +: ddf_pkg::SCORE_W]),
			.win_s1  (win_s1[g])
		);
	end

	ddf_merge #(
		.NUM_CLASSES(NUM_CLASSES)
	) u_merge (
		.clk     (clk),
		.en      (rdy2),
		.win_s1  (win_s1),
		.score_s1(score_s1),
		.pick_s2 (pick_s2)
	);

	ddf_decide #(
		.NUM_CLASSES(NUM_CLASSES),
		.COUNT_BITS (COUNT_BITS)
	) u_decide (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (rdy3 && vld_s2),
		.cfg      (cfg_q),
		.pick_s2  (pick_s2),
		.window_s2(window_s2),
		.peak_s2  (peak_s2),
		.result_q (result_q)
	);

	assign m_tdata = {1'b0, result_q.gated_cnt, result_q.suppressed, result_q.held,
		result_q.reported, result_q.gated, result_q.led, result_q.pct, result_q.cls,
		result_q.action, result_q.window};

endmodule

// ===== sv/ddf_lane.sv =====
// One class lane: decides whether its class holds the first highest score.
// Depends on ddf_pkg.
module ddf_lane #(
	parameter int NUM_CLASSES = ddf_pkg::NUM_CLASSES_DEF,
	parameter int LANE        = 0
) (
	input  logic                                    clk,
	input  logic                                    en,
	input  logic [NUM_CLASSES*ddf_pkg::SCORE_W-1:0] scores,
	output logic [ddf_pkg::SCORE_W-1:0]             score_s1,
	output logic                                    win_s1
);

	logic [ddf_pkg::SCORE_W-1:0] own;
	logic                        win;

	assign own = scores[LANE*ddf_pkg::SCORE_W +: ddf_pkg::SCORE_W];

	always_comb begin
		win = 1'b1;
		for (int j = 0; j < NUM_CLASSES; j++) begin
			if (j < LANE) begin
				if (!(own > scores[j*ddf_pkg::SCORE_W +: ddf_pkg::SCORE_W]))
					win = 1'b0;
			end else if (j > LANE) begin
				if (own < scores[j*ddf_pkg::SCORE_W +: ddf_pkg::SCORE_W])
					win = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			score_s1 <= own;
			win_s1   <= win;
		end
	end

endmodule

// ===== sv/ddf_merge.sv =====
// Merges the lane results into the winning class index and its score.
// Depends on ddf_pkg.
module ddf_merge #(
	parameter int NUM_CLASSES = ddf_pkg::NUM_CLASSES_DEF
) (
	input  logic                                    clk,
	input  logic                                    en,
	input  logic [NUM_CLASSES-1:0]                  win_s1,
	input  logic [NUM_CLASSES*ddf_pkg::SCORE_W-1:0] score_s1,
	output ddf_pkg::pick_t                          pick_s2
);

	ddf_pkg::pick_t pick;

	always_comb begin
		pick = '0;
		for (int i = 0; i < NUM_CLASSES; i++) begin
			if (win_s1[i]) begin
				pick.top  = pick.top | ddf_pkg::CLASS_W'(i);
				pick.best = pick.best | score_s1[i*ddf_pkg::SCORE_W +: ddf_pkg::SCORE_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			pick_s2 <= pick;
	end

endmodule

// ===== sv/ddf_decide.sv =====
// Decision stage: threshold, peak gate, target filter, hold logic and totals.
// Holds the output register. Depends on ddf_pkg.
module ddf_decide #(
	parameter int NUM_CLASSES = ddf_pkg::NUM_CLASSES_DEF,
	parameter int COUNT_BITS  = ddf_pkg::COUNT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  ddf_pkg::cfg_t                cfg,
	input  ddf_pkg::pick_t               pick_s2,
	input  logic [ddf_pkg::WIN_W-1:0]    window_s2,
	input  logic [ddf_pkg::PEAK_W-1:0]   peak_s2,
	output ddf_pkg::result_t             result_q
);

	localparam logic [ddf_pkg::CLASS_W-1:0] UNK = ddf_pkg::CLASS_W'(NUM_CLASSES);

	logic                            last_unk_q;
	logic                            first_q;
	logic [COUNT_BITS-1:0]           reported_q;
	logic [COUNT_BITS-1:0]           held_q;
	logic [COUNT_BITS-1:0]           suppressed_q;
	logic [COUNT_BITS-1:0]           gated_q;

	logic                            named;
	logic                            gated;
	logic                            is_unk;
	logic                            is_tgt;
	logic [ddf_pkg::CLASS_W-1:0]     cls;
	logic [22:0]                     prod;
	logic [ddf_pkg::PCT_W-1:0]       pct;
	ddf_pkg::action_t                action;
	logic [COUNT_BITS-1:0]           reported_n;
	logic [COUNT_BITS-1:0]           held_n;
	logic [COUNT_BITS-1:0]           suppressed_n;
	logic [COUNT_BITS-1:0]           gated_n;

	always_comb begin
		named  = pick_s2.best > cfg.threshold;
		gated  = named && (cfg.gate != '0) && (peak_s2 < cfg.gate);
		is_unk = !named || gated;
		cls    = is_unk ? UNK : pick_s2.top;
		is_tgt = 1'b0;
		for (int i = 0; i < ddf_pkg::MASK_W; i++) begin
			if (!is_unk && cls == ddf_pkg::CLASS_W'(i))
				is_tgt = cfg.mask[i];
		end

		prod = 23'(pick_s2.best) * 23'(ddf_pkg::PCT_SCALE) + ddf_pkg::PCT_ROUND;
		pct  = (prod[22:16] > ddf_pkg::PCT_MAX) ? ddf_pkg::PCT_MAX : prod[22:16];

		reported_n   = reported_q;
		held_n       = held_q;
		suppressed_n = suppressed_q;
		gated_n      = gated ? gated_q + 1'b1 : gated_q;
		if (!is_unk && !is_tgt) begin
			action       = ddf_pkg::ACT_SUPPRESSED;
			suppressed_n = suppressed_q + 1'b1;
		end else if (is_unk && !first_q && last_unk_q) begin
			action = ddf_pkg::ACT_HELD;
			held_n = held_q + 1'b1;
		end else begin
			action     = is_unk ? ddf_pkg::ACT_UNKNOWN : ddf_pkg::ACT_TARGET;
			reported_n = reported_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_unk_q   <= 1'b1;
			first_q      <= 1'b1;
			reported_q   <= '0;
			held_q       <= '0;
			suppressed_q <= '0;
			gated_q      <= '0;
		end else if (en) begin
			reported_q   <= reported_n;
			held_q       <= held_n;
			suppressed_q <= suppressed_n;
			gated_q      <= gated_n;
			if (action == ddf_pkg::ACT_SUPPRESSED) begin
				last_unk_q <= 1'b1;
			end else if (action != ddf_pkg::ACT_HELD) begin
				last_unk_q <= is_unk;
				first_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q.window     <= window_s2;
			result_q.action     <= action;
			result_q.cls        <= cls;
			result_q.pct        <= pct;
			result_q.led        <= (action == ddf_pkg::ACT_TARGET);
			result_q.gated      <= gated;
			result_q.reported   <= ddf_pkg::CNT_OUT_W'(reported_n);
			result_q.held       <= ddf_pkg::CNT_OUT_W'(held_n);
			result_q.suppressed <= ddf_pkg::CNT_OUT_W'(suppressed_n);
			result_q.gated_cnt  <= ddf_pkg::CNT_OUT_W'(gated_n);
		end
	end

endmodule

// ===== tb/ddf_decision_check_pkg.sv =====
// Expected-decision bookkeeping for the detection decision filter testbench.
// Holds a copy of the filter's registers and totals and checks each output transfer.
// Depends on ddf_pkg for widths, register indexes and the action codes.
package ddf_decision_check_pkg;
	import ddf_pkg::*;

	localparam int IN_W  = 208;
	localparam int OUT_W = 176;
	localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = CLASS_W'(NUM_CLASSES_DEF);

	class decision_checker;
		logic [SCORE_W-1:0] threshold;
		logic [SCORE_W-1:0] gate;
		logic [MASK_W-1:0]  mask;
		bit                 last_unknown;
		bit                 none_reported;
		logic [31:0]        reported_tot;
		logic [31:0]        held_tot;
		logic [31:0]        supp_tot;
		logic [31:0]        gated_tot;
		result_t            pending[$];
		int                 errors;
		int                 checked;
		int                 action_seen[4];
		int                 gated_seen;

		function new();
			threshold     = THRESHOLD_RST;
			gate          = '0;
			mask          = '0;
			last_unknown  = 1'b1;
			none_reported = 1'b1;
			reported_tot  = '0;
			held_tot      = '0;
			supp_tot      = '0;
			gated_tot     = '0;
			errors        = 0;
			checked       = 0;
			gated_seen    = 0;
			foreach (action_seen[i]) action_seen[i] = 0;
		endfunction

		function void write_reg(logic [ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_THRESHOLD: threshold = val;
				REG_GATE:      gate = val;
				REG_MASK:      mask = val[MASK_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending_count();
			return pending.size();
		endfunction

		function result_t decide(logic [IN_W-1:0] d);
			logic [NUM_CLASSES_DEF-1:0][SCORE_W-1:0] sc;
			logic [PEAK_W-1:0]  peak;
			logic [SCORE_W-1:0] best;
			logic [CLASS_W-1:0] top;
			logic [CLASS_W-1:0] cls;
			int unsigned        p;
			result_t            r;
			sc   = d[191:32];
			peak = d[207:192];
			best = sc[0];
			top  = '0;
			for (int i = 1; i < NUM_CLASSES_DEF; i++) begin
				if (sc[i] > best) begin
					best = sc[i];
					top  = CLASS_W'(i);
				end
			end
			cls = (best > threshold) ? top : CLASS_UNKNOWN;
			p = (32'(best) * 32'd100 + 32'd32768) >> 16;
			if (p > 32'(PCT_MAX))
				p = 32'(PCT_MAX);
			r = '0;
			r.window = d[31:0];
			if (cls != CLASS_UNKNOWN && gate != '0 && peak < gate) begin
				gated_tot = gated_tot + 32'd1;
				cls = CLASS_UNKNOWN;
				r.gated = 1'b1;
			end
			if (cls != CLASS_UNKNOWN && !mask[cls]) begin
				supp_tot = supp_tot + 32'd1;
				last_unknown = 1'b1;
				r.action = ACT_SUPPRESSED;
			end else if (cls == CLASS_UNKNOWN && !none_reported && last_unknown) begin
				held_tot = held_tot + 32'd1;
				r.action = ACT_HELD;
			end else begin
				r.action = (cls == CLASS_UNKNOWN) ? ACT_UNKNOWN : ACT_TARGET;
				r.led = (cls != CLASS_UNKNOWN);
				last_unknown = (cls == CLASS_UNKNOWN);
				none_reported = 1'b0;
				reported_tot = reported_tot + 32'd1;
			end
			r.cls        = cls;
			r.pct        = PCT_W'(p);
			r.reported   = reported_tot;
			r.held       = held_tot;
			r.suppressed = supp_tot;
			r.gated_cnt  = gated_tot;
			return r;
		endfunction

		function void note_window(logic [IN_W-1:0] d);
			pending.push_back(decide(d));
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_decision(logic [OUT_W-1:0] d);
			result_t want;
			if (pending.size() == 0) begin
				$error("decision for window %0d arrived with none expected", d[31:0]);
				errors++;
				return;
			end
			want = pending.pop_front();
			compare("window_out", want.window, d[31:0]);
			compare("action", 32'(want.action), 32'(d[33:32]));
			compare("class_out", 32'(want.cls), 32'(d[37:34]));
			compare("percent", 32'(want.pct), 32'(d[44:38]));
			compare("led_trigger", 32'(want.led), 32'(d[45]));
			compare("was_gated", 32'(want.gated), 32'(d[46]));
			compare("reported_count", want.reported, d[78:47]);
			compare("held_count", want.held, d[110:79]);
			compare("suppressed_count", want.suppressed, d[142:111]);
			compare("gated_count", want.gated_cnt, d[174:143]);
			checked++;
			action_seen[want.action]++;
			if (want.gated)
				gated_seen++;
		endfunction
	endclass

endpackage

// ===== tb/tb_detection_decision_filter.sv =====
// Top-level testbench for detection_decision_filter: directed windows, then random
// windows under several idle and stall patterns and register settings.
// Depends on ddf_pkg and ddf_decision_check_pkg.
module tb_detection_decision_filter;
	timeunit 1ns;
	timeprecision 1ps;
	import ddf_pkg::*;
	import ddf_decision_check_pkg::*;

	localparam logic [ADDR_W-1:0] REG_SPARE = 2'd3;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b1;
	logic [OUT_W-1:0] m_tdata;
	logic             cfg_wr_en = 1'b0;
	logic [ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	decision_checker chk = new();
	bit          s_fire;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          rx_hold_left;
	int          settings;
	logic [31:0] next_win;

	detection_decision_filter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk) begin
		s_fire = s_tvalid && s_tready;
		if (s_fire)
			chk.note_window(s_tdata);
		if (m_tvalid && m_tready)
			chk.check_decision(m_tdata);
	end

	initial begin
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				m_tready <= 1'b0;
				rx_hold_left--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	function automatic logic [IN_W-1:0] pack_window(logic [31:0] win,
			logic [NUM_CLASSES_DEF-1:0][SCORE_W-1:0] sc, logic [PEAK_W-1:0] pk);
		return {pk, sc, win};
	endfunction

	task automatic send_window(logic [IN_W-1:0] d);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		do @(negedge clk); while (!s_fire);
	endtask

	task automatic send_pick(logic [31:0] win, int c, logic [15:0] top, logic [15:0] other,
			logic [15:0] pk);
		logic [NUM_CLASSES_DEF-1:0][SCORE_W-1:0] sc;
		for (int i = 0; i < NUM_CLASSES_DEF; i++) sc[i] = other;
		sc[c] = top;
		send_window(pack_window(win, sc, pk));
	endtask

	task automatic send_random();
		logic [NUM_CLASSES_DEF-1:0][SCORE_W-1:0] sc;
		int kind;
		int c;
		int t;
		int pk;
		logic [15:0] v;
		kind = $urandom_range(0, 99);
		c = $urandom_range(0, NUM_CLASSES_DEF - 1);
		if (kind < 60) begin
			t = int'(chk.threshold) + int'($urandom_range(0, 8)) - 4;
			if (t < 0)
				t = 0;
			if (t > 65535)
				t = 65535;
			if ($urandom_range(0, 3) == 0)
				t = int'($urandom_range(32'(chk.threshold), 65535));
			for (int i = 0; i < NUM_CLASSES_DEF; i++)
				sc[i] = (t == 0) ? 16'd0 : 16'($urandom_range(0, t - 1));
			sc[c] = 16'(t);
			if (c > 0 && $urandom_range(0, 6) == 0)
				sc[$urandom_range(0, c - 1)] = 16'(t);
		end else if (kind < 80) begin
			for (int i = 0; i < NUM_CLASSES_DEF; i++) sc[i] = 16'($urandom);
		end else if (kind < 90) begin
			v = 16'($urandom);
			for (int i = 0; i < NUM_CLASSES_DEF; i++) sc[i] = v;
		end else begin
			v = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
			for (int i = 0; i < NUM_CLASSES_DEF; i++) sc[i] = v;
			if ($urandom_range(0, 1) == 1)
				sc[c] = ~v;
		end
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				pk = int'(chk.gate) + int'($urandom_range(0, 2)) - 1;
				if (pk < 0)
					pk = 0;
				if (pk > 32768)
					pk = 32768;
			end
			4: pk = 32768;
			5: pk = 0;
			default: pk = int'($urandom_range(0, 32768));
		endcase
		if ($urandom_range(0, 19) == 0)
			next_win = $urandom;
		send_window(pack_window(next_win, sc, 16'(pk)));
		next_win = next_win + 32'd1;
	endtask

	task automatic wait_settled();
		s_tvalid <= 1'b0;
		while (chk.pending_count() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_regs(logic [15:0] thr, logic [15:0] gt, logic [15:0] msk);
		logic [15:0] spare;
		spare = 16'($urandom);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= REG_THRESHOLD;
		cfg_wdata <= thr;
		chk.write_reg(REG_THRESHOLD, thr);
		@(negedge clk);
		cfg_addr  <= REG_GATE;
		cfg_wdata <= gt;
		chk.write_reg(REG_GATE, gt);
		@(negedge clk);
		cfg_addr  <= REG_MASK;
		cfg_wdata <= msk;
		chk.write_reg(REG_MASK, msk);
		@(negedge clk);
		cfg_addr  <= REG_SPARE;
		cfg_wdata <= spare;
		chk.write_reg(REG_SPARE, spare);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		settings++;
	endtask

	task automatic write_random_regs();
		logic [15:0] thr;
		logic [15:0] gt;
		logic [15:0] msk;
		case ($urandom_range(0, 5))
			0: thr = 16'h0000;
			1: thr = 16'hFFFF;
			2, 3: thr = 16'($urandom);
			default: thr = 16'($urandom_range(30000, 36000));
		endcase
		case ($urandom_range(0, 4))
			0, 2: gt = 16'h0000;
			1: gt = 16'h8000;
			default: gt = 16'($urandom_range(0, 32768));
		endcase
		case ($urandom_range(0, 3))
			0: msk = {6'($urandom), 10'h000};
			1: msk = {6'($urandom), 10'h3FF};
			default: msk = 16'($urandom);
		endcase
		write_regs(thr, gt, msk);
	endtask

	initial begin
		int send_pcts[4];
		int recv_pcts[4];
		int n;
		send_pcts = '{0, 79, 0, 38};
		recv_pcts = '{0, 0, 79, 38};
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		rx_hold_left   = 0;
		settings       = 0;
		next_win       = 32'd100;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset register values: nothing is a target, threshold at one half.
		send_pick(32'd0, 0, 16'h0000, 16'h0000, 16'd0);
		send_pick(32'hFFFF_FFFF, 4, 16'hFFFF, 16'h0000, 16'd32768);
		send_pick(32'd2, 2, 16'h8000, 16'd100, 16'd10);
		send_pick(32'd3, 7, 16'h8001, 16'h0000, 16'd0);
		wait_settled();
		write_regs(16'h4000, 16'd1000, 16'hFFFF);
		send_pick(32'd4, 9, 16'hFFFF, 16'hFFFF, 16'd999);
		send_pick(32'd5, 9, 16'hC000, 16'h0000, 16'd1000);
		send_pick(32'd6, 1, 16'd100, 16'd50, 16'd32768);
		send_pick(32'd7, 1, 16'd100, 16'd50, 16'd32768);
		send_pick(32'd8, 3, 16'h4001, 16'h4000, 16'd32768);
		send_pick(32'd9, 5, 16'hFFFF, 16'hFFFE, 16'd0);
		wait_settled();
		write_regs(16'h0000, 16'd32768, 16'h0155);
		send_pick(32'd10, 2, 16'd1, 16'd0, 16'd32768);
		send_pick(32'd11, 1, 16'd655, 16'd0, 16'd32768);
		send_pick(32'd12, 0, 16'd0, 16'd0, 16'd32767);
		send_pick(32'd13, 8, 16'h8000, 16'd0, 16'd32767);
		send_pick(32'd14, 6, 16'd32440, 16'd0, 16'd32768);
		wait_settled();
		write_regs(16'hFFFF, 16'd0, 16'h02AA);
		send_pick(32'd15, 9, 16'hFFFF, 16'hFFFF, 16'd5);
		send_pick(32'd16, 0, 16'hFFFF, 16'h0000, 16'd0);
		wait_settled();

		// Output held off for a long stretch while windows keep coming.
		write_regs(16'h2000, 16'd0, 16'h03FF);
		@(posedge clk);
		rx_hold_left = 300;
		@(negedge clk);
		repeat (16) send_random();
		wait_settled();

		for (int p = 0; p < 4; p++) begin
			@(posedge clk);
			send_idle_pct  = send_pcts[p];
			recv_stall_pct = recv_pcts[p];
			@(negedge clk);
			for (int b = 0; b < 9; b++) begin
				write_random_regs();
				repeat (31) send_random();
				wait_settled();
			end
		end

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		n = 0;
		while (chk.pending_count() != 0 && n < 5000) begin
			@(negedge clk);
			n++;
		end
		repeat (8) @(negedge clk);
		if (chk.pending_count() != 0) begin
			$error("%0d expected decisions never arrived", chk.pending_count());
			chk.errors++;
		end
		$display("Checked %0d decisions over %0d register settings and four idle patterns.",
			chk.checked, settings);
		$display("Actions: %0d target, %0d unknown, %0d held, %0d suppressed; %0d gated.",
			chk.action_seen[ACT_TARGET], chk.action_seen[ACT_UNKNOWN],
			chk.action_seen[ACT_HELD], chk.action_seen[ACT_SUPPRESSED], chk.gated_seen);
		if (chk.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
